// File: hdl/clc_pkg.sv
// Shared types, range limits and digit helpers for the card number classifier.
package clc_pkg;

  // Input width and the width of the value that goes through binary to BCD.
  // 56 bits cover every number below 10^16 and split evenly into 4-bit stages.
  localparam int CARD_W       = 63;
  localparam int VAL_W        = 56;
  localparam int BITS_PER_STG = 4;
  localparam int DD_STAGES    = VAL_W / BITS_PER_STG;
  localparam int SUM_W        = 8;

  typedef logic [CARD_W-1:0] card_num_t;
  typedef logic [1:0]        card_class_t;

  localparam card_class_t CLASS_INVALID    = 2'd0;
  localparam card_class_t CLASS_AMEX       = 2'd1;
  localparam card_class_t CLASS_MASTERCARD = 2'd2;
  localparam card_class_t CLASS_VISA       = 2'd3;

  // Decimal ranges of each class
  localparam card_num_t AMEX34_LO = 63'd340000000000000;
  localparam card_num_t AMEX34_HI = 63'd349999999999999;
  localparam card_num_t AMEX37_LO = 63'd370000000000000;
  localparam card_num_t AMEX37_HI = 63'd379999999999999;
  localparam card_num_t MC_LO     = 63'd5100000000000000;
  localparam card_num_t MC_HI     = 63'd5599999999999999;
  localparam card_num_t VISA16_LO = 63'd4000000000000000;
  localparam card_num_t VISA16_HI = 63'd4999999999999999;
  localparam card_num_t VISA13_LO = 63'd4000000000000;
  localparam card_num_t VISA13_HI = 63'd4999999999999;

  // Valid bit and class travel together down the pipeline
  typedef struct packed {
    logic        valid;
    card_class_t cls;
  } pipe_ctl_t;

  // Double a decimal digit and add the digits of the product
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    return (d < 4'd5) ? t[3:0] : 4'(t - 5'd9);
  endfunction

  // True when the sum is a multiple of ten
  function automatic logic luhn_mod10_zero(input logic [SUM_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= 25; k++) begin
      hit = hit | (s == SUM_W'(10 * k));
    end
    return hit;
  endfunction

endpackage

// File: hdl/clc_range_stage.sv
// First pipeline stage: place the card number into a class by decimal range.
module clc_range_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  clc_pkg::card_num_t      num_i,
  output clc_pkg::pipe_ctl_t      ctl_o,
  output logic [clc_pkg::VAL_W-1:0] val_o,
  input  logic                    ready_i
);
  import clc_pkg::*;

  logic              vld_r;
  card_class_t       cls_r;
  card_class_t       cls_nxt;
  logic [VAL_W-1:0]  val_r;

  // Compare against every range in parallel, then pick by priority
  always_comb begin
    cls_nxt = CLASS_INVALID;
    if ((num_i >= AMEX34_LO && num_i <= AMEX34_HI) ||
        (num_i >= AMEX37_LO && num_i <= AMEX37_HI)) begin
      cls_nxt = CLASS_AMEX;
    end else if (num_i >= MC_LO && num_i <= MC_HI) begin
      cls_nxt = CLASS_MASTERCARD;
    end else if ((num_i >= VISA16_LO && num_i <= VISA16_HI) ||
                 (num_i >= VISA13_LO && num_i <= VISA13_HI)) begin
      cls_nxt = CLASS_VISA;
    end
  end

  // Stage advances when empty or when the next stage takes its item
  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  // Any number in a range is below 10^16, so the low bits are enough
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cls_r <= cls_nxt;
      val_r <= num_i[VAL_W-1:0];
    end
  end

  assign ctl_o = '{valid: vld_r, cls: cls_r};
  assign val_o = val_r;

endmodule

// File: hdl/clc_bcd_stage.sv
// One binary to BCD stage: shifts four value bits into the BCD digits.
module clc_bcd_stage #(
  parameter int DIGITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  clc_pkg::pipe_ctl_t        ctl_i,
  output logic                      ready_o,
  input  logic [clc_pkg::VAL_W-1:0] bin_i,
  input  logic [4*DIGITS-1:0]       bcd_i,
  output clc_pkg::pipe_ctl_t        ctl_o,
  output logic [clc_pkg::VAL_W-1:0] bin_o,
  output logic [4*DIGITS-1:0]       bcd_o,
  input  logic                      ready_i
);
  import clc_pkg::*;

  localparam int BCD_W = 4 * DIGITS;

  logic              vld_r;
  card_class_t       cls_r;
  logic [VAL_W-1:0]  bin_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [VAL_W-1:0]  bin_nxt;
  logic [BCD_W-1:0]  bcd_nxt;

  // Adjust each digit of five or more by three, then shift in the next bit
  always_comb begin
    bin_nxt = bin_i;
    bcd_nxt = bcd_i;
    for (int b = 0; b < BITS_PER_STG; b++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_nxt[j*4 +: 4] >= 4'd5) begin
          bcd_nxt[j*4 +: 4] = bcd_nxt[j*4 +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VAL_W-1]};
      bin_nxt = {bin_nxt[VAL_W-2:0], 1'b0};
    end
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      cls_r <= ctl_i.cls;
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign ctl_o = '{valid: vld_r, cls: cls_r};
  assign bin_o = bin_r;
  assign bcd_o = bcd_r;

endmodule

// File: hdl/clc_luhn_sum.sv
// Luhn sum over the decimal digits, in a pair stage and a total stage.
module clc_luhn_sum #(
  parameter int DIGITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  clc_pkg::pipe_ctl_t        ctl_i,
  output logic                      ready_o,
  input  logic [4*DIGITS-1:0]       bcd_i,
  output clc_pkg::pipe_ctl_t        ctl_o,
  output logic [clc_pkg::SUM_W-1:0] sum_o,
  input  logic                      ready_i
);
  import clc_pkg::*;

  localparam int NPAIR = (DIGITS + 1) / 2;
  localparam int PAD_W = NPAIR * 8;

  logic              vld1_r;
  logic              vld2_r;
  card_class_t       cls1_r;
  card_class_t       cls2_r;
  logic              rdy1;
  logic              rdy2;
  logic [PAD_W-1:0]  bcd_pad;
  logic [4:0]        pair_nxt [NPAIR];
  logic [4:0]        pair_r   [NPAIR];
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum_r;

  // Pair each plain digit with the doubled digit to its left
  assign bcd_pad = PAD_W'(bcd_i);

  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      pair_nxt[p] = 5'(bcd_pad[p*8 +: 4]) + 5'(luhn_dbl(bcd_pad[p*8+4 +: 4]));
    end
  end

  // Add the pair sums
  always_comb begin
    sum_nxt = '0;
    for (int p = 0; p < NPAIR; p++) begin
      sum_nxt = sum_nxt + SUM_W'(pair_r[p]);
    end
  end

  assign rdy2    = !vld2_r || ready_i;
  assign rdy1    = !vld1_r || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        vld1_r <= ctl_i.valid;
      end
      if (rdy2) begin
        vld2_r <= vld1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && ctl_i.valid) begin
      cls1_r <= ctl_i.cls;
      pair_r <= pair_nxt;
    end
    if (rdy2 && vld1_r) begin
      cls2_r <= cls1_r;
      sum_r  <= sum_nxt;
    end
  end

  assign ctl_o = '{valid: vld2_r, cls: cls2_r};
  assign sum_o = sum_r;

  // Sum of valid decimal digits never exceeds nine per digit
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> sum_r <= SUM_W'(9 * DIGITS))
    else $error("luhn sum exceeds digit bound");

  // Total stage holds its item while the receiver stalls
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r && !ready_i |=> vld2_r && $stable(sum_r) && $stable(cls2_r))
    else $error("luhn sum changed while stalled");

endmodule

// File: hdl/clc_check_stage.sv
// Output stage: keep the class only when the Luhn sum is a multiple of ten.
module clc_check_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  clc_pkg::pipe_ctl_t        ctl_i,
  output logic                      ready_o,
  input  logic [clc_pkg::SUM_W-1:0] sum_i,
  output logic                      valid_o,
  output clc_pkg::card_class_t      cls_o,
  input  logic                      ready_i
);
  import clc_pkg::*;

  logic         vld_r;
  card_class_t  cls_r;
  card_class_t  cls_nxt;

  // Drop the class on a failed check
  assign cls_nxt = luhn_mod10_zero(sum_i) ? ctl_i.cls : CLASS_INVALID;

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      cls_r <= cls_nxt;
    end
  end

  assign valid_o = vld_r;
  assign cls_o   = cls_r;

endmodule

// File: hdl/card_number_luhn_classifier.sv
// Top level of the card number classifier pipeline.
//
// Input channel: in_valid / in_ready carry one 63-bit card number per transfer.
// Output channel: out_valid / out_ready carry one 2-bit class per transfer:
// 0 invalid, 1 amex, 2 mastercard, 3 visa. Results leave in input order.
//
// Pipeline: one range-compare stage, DD_STAGES (14) binary to BCD stages of
// four bits each, a pair-sum stage, a total stage and a registered check
// stage. Throughput is one number per cycle while out_ready is high; every
// stage has its own valid bit, so the pipeline keeps filling bubbles while
// the receiver stalls and only backs up to in_ready once all 18 stages
// hold an item.
//
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline comes
// out of reset empty with in_ready high. MAX_DIGITS sets the number of
// decimal digits in the BCD word and the Luhn sum (16 to 19).
module card_number_luhn_classifier #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  clc_pkg::card_num_t   in_card_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clc_pkg::card_class_t out_card_class
);
  import clc_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;

  pipe_ctl_t         ctl_s [DD_STAGES+1];
  logic              rdy_s [DD_STAGES+1];
  logic [VAL_W-1:0]  bin_s [DD_STAGES+1];
  logic [BCD_W-1:0]  bcd_s [DD_STAGES+1];
  pipe_ctl_t         sum_ctl;
  logic [SUM_W-1:0]  sum_v;
  logic              sum_rdy;

  // Range compare
  clc_range_stage u_range (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .num_i   (in_card_number),
    .ctl_o   (ctl_s[0]),
    .val_o   (bin_s[0]),
    .ready_i (rdy_s[0])
  );

  assign bcd_s[0] = '0;

  // Binary to BCD chain
  for (genvar k = 0; k < DD_STAGES; k++) begin : g_bcd
    clc_bcd_stage #(
      .DIGITS (MAX_DIGITS)
    ) u_bcd (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl_s[k]),
      .ready_o (rdy_s[k]),
      .bin_i   (bin_s[k]),
      .bcd_i   (bcd_s[k]),
      .ctl_o   (ctl_s[k+1]),
      .bin_o   (bin_s[k+1]),
      .bcd_o   (bcd_s[k+1]),
      .ready_i (rdy_s[k+1])
    );
  end

  // Luhn sum
  clc_luhn_sum #(
    .DIGITS (MAX_DIGITS)
  ) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_s[DD_STAGES]),
    .ready_o (rdy_s[DD_STAGES]),
    .bcd_i   (bcd_s[DD_STAGES]),
    .ctl_o   (sum_ctl),
    .sum_o   (sum_v),
    .ready_i (sum_rdy)
  );

  // Mod-10 check and output register
  clc_check_stage u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (sum_ctl),
    .ready_o (sum_rdy),
    .sum_i   (sum_v),
    .valid_o (out_valid),
    .cls_o   (out_card_class),
    .ready_i (out_ready)
  );

  // Every value bit has been shifted into the digits by the last BCD stage
  a_bin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[DD_STAGES].valid |-> bin_s[DD_STAGES] == '0)
    else $error("binary value not fully converted");

  // An open receiver never backs up the pipeline
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule
